// ----- rtl/mkd_pkg.sv -----
// mkd_pkg: word types, register indexes, status codes and the Morse table
// for the keyer decoder. No dependencies.
package mkd_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] level;
    } t_in_word;

    typedef struct packed {
        logic [6:0] char_code;
        logic [1:0] status;
    } t_out_word;

    typedef enum logic [1:0] {
        REG_LOW_LEVEL  = 2'd0,
        REG_HIGH_LEVEL = 2'd1,
        REG_SHORT_MAX  = 2'd2,
        REG_LONG_MAX   = 2'd3
    } t_reg_index;

    localparam logic [1:0] STATUS_DECODED   = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_ABORTED   = 2'd2;

    localparam logic KIND_LEVEL = 1'b0;

    localparam logic [15:0] LOW_LEVEL_RESET  = 16'd0;
    localparam logic [15:0] HIGH_LEVEL_RESET = 16'd1;
    localparam logic [15:0] SHORT_MAX_RESET  = 16'd200;
    localparam logic [15:0] LONG_MAX_RESET   = 16'd600;

    // bit i of bits is the symbol at position i, 1 = dash; returns 0 if not found
    function automatic logic [6:0] f_lookup(input logic [2:0] cnt, input logic [6:0] bits);
        logic [6:0] code;
        code = 7'h00;
        case ({cnt, bits})
            {3'd2, 7'b0000010}: code = 7'h61; // a
            {3'd4, 7'b0000001}: code = 7'h62; // b
            {3'd4, 7'b0000101}: code = 7'h63; // c
            {3'd3, 7'b0000001}: code = 7'h64; // d
            {3'd1, 7'b0000000}: code = 7'h65; // e
            {3'd4, 7'b0000100}: code = 7'h66; // f
            {3'd3, 7'b0000011}: code = 7'h67; // g
            {3'd4, 7'b0000000}: code = 7'h68; // h
            {3'd2, 7'b0000000}: code = 7'h69; // i
            {3'd4, 7'b0001110}: code = 7'h6a; // j
            {3'd3, 7'b0000101}: code = 7'h6b; // k
            {3'd4, 7'b0000010}: code = 7'h6c; // l
            {3'd2, 7'b0000011}: code = 7'h6d; // m
            {3'd2, 7'b0000001}: code = 7'h6e; // n
            {3'd3, 7'b0000111}: code = 7'h6f; // o
            {3'd4, 7'b0000110}: code = 7'h70; // p
            {3'd4, 7'b0001011}: code = 7'h71; // q
            {3'd3, 7'b0000010}: code = 7'h72; // r
            {3'd3, 7'b0000000}: code = 7'h73; // s
            {3'd1, 7'b0000001}: code = 7'h74; // t
            {3'd3, 7'b0000100}: code = 7'h75; // u
            {3'd4, 7'b0001000}: code = 7'h76; // v
            {3'd3, 7'b0000110}: code = 7'h77; // w
            {3'd4, 7'b0001001}: code = 7'h78; // x
            {3'd4, 7'b0001101}: code = 7'h79; // y
            {3'd4, 7'b0000011}: code = 7'h7a; // z
            {3'd5, 7'b0011110}: code = 7'h31;
            {3'd5, 7'b0011100}: code = 7'h32;
            {3'd5, 7'b0011000}: code = 7'h33;
            {3'd5, 7'b0010000}: code = 7'h34;
            {3'd5, 7'b0000000}: code = 7'h35;
            {3'd5, 7'b0000001}: code = 7'h36;
            {3'd5, 7'b0000011}: code = 7'h37;
            {3'd5, 7'b0000111}: code = 7'h38;
            {3'd5, 7'b0001111}: code = 7'h39;
            {3'd5, 7'b0011111}: code = 7'h30;
            {3'd6, 7'b0101010}: code = 7'h2e; // period
            {3'd6, 7'b0110011}: code = 7'h2c; // comma
            {3'd6, 7'b0001100}: code = 7'h3f; // question mark
            {3'd6, 7'b0011110}: code = 7'h27; // apostrophe
            {3'd6, 7'b0110101}: code = 7'h21; // exclamation mark
            {3'd5, 7'b0001001}: code = 7'h2f; // slash
            {3'd5, 7'b0001101}: code = 7'h28; // open paren
            {3'd6, 7'b0101101}: code = 7'h29; // close paren
            {3'd5, 7'b0000010}: code = 7'h26; // ampersand
            {3'd6, 7'b0000111}: code = 7'h3a; // colon
            {3'd6, 7'b0010101}: code = 7'h3b; // semicolon
            {3'd5, 7'b0010001}: code = 7'h3d; // equals
            {3'd5, 7'b0001010}: code = 7'h2b; // plus
            {3'd6, 7'b0100001}: code = 7'h2d; // hyphen
            {3'd6, 7'b0101100}: code = 7'h5f; // underscore
            {3'd6, 7'b0010010}: code = 7'h22; // quote
            {3'd7, 7'b1001000}: code = 7'h24; // dollar
            {3'd6, 7'b0010110}: code = 7'h40; // at sign
            default:            code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/morse_keyer_decoder.sv -----
// morse_keyer_decoder: Morse decoder for a sampled key level and time ticks.
// Depends on mkd_pkg (word types, register indexes, status codes, code table).
//
//   channel  direction  handshake                  word
//   in       sink       i_in_valid / o_in_stall     t_in_word  (kind, level)
//   out      source     o_out_valid / i_out_stall   t_out_word (char_code, status)
//   cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One word per cycle unless the input stalls: state updates at the accepting
// edge, a result lands in the output register on the same edge and shows on
// the next cycle. The output register holds one result; the input stalls only
// while that result is held by a stall on the output side.
// Reset is synchronous and restores register defaults and an empty buffer.
module morse_keyer_decoder #(
    parameter int MAX_SYMBOLS = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mkd_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mkd_pkg::t_out_word o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import mkd_pkg::*;

    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int IW = $clog2(MAX_SYMBOLS);

    logic [15:0] r_low_level, r_high_level, r_short_max, r_long_max;
    logic [15:0] r_last_level, n_last_level;
    logic        r_last_valid, n_last_valid;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_armed, n_armed;
    logic [MAX_SYMBOLS-1:0] r_sym_bits, n_sym_bits;
    logic [CW-1:0] r_sym_cnt, n_sym_cnt;
    logic        r_sym_ovf, n_sym_ovf;
    logic        r_out_valid;
    t_out_word   r_out_word, n_out_word;
    logic        n_fire;

    logic        w_accept;
    logic [15:0] w_elapsed_inc;
    logic [6:0]  w_bits_ext;
    logic [3:0]  w_cnt_ext;
    logic [6:0]  w_code;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign w_bits_ext    = 7'(r_sym_bits);
    assign w_cnt_ext     = 4'(r_sym_cnt);

    always_comb begin
        if (r_sym_ovf || w_cnt_ext == 4'd0 || w_cnt_ext > 4'd7) begin
            w_code = 7'h00;
        end else begin
            w_code = f_lookup(w_cnt_ext[2:0], w_bits_ext);
        end
    end

    always_comb begin
        n_last_level = r_last_level;
        n_last_valid = r_last_valid;
        n_elapsed    = r_elapsed;
        n_armed      = r_armed;
        n_sym_bits   = r_sym_bits;
        n_sym_cnt    = r_sym_cnt;
        n_sym_ovf    = r_sym_ovf;
        n_fire       = 1'b0;
        n_out_word   = r_out_word;
        if (i_in_word.kind == KIND_LEVEL) begin
            if (!(r_last_valid && i_in_word.level == r_last_level)) begin
                if (i_in_word.level > r_low_level) begin
                    if (r_last_valid && r_last_level == r_low_level) begin
                        if (r_sym_cnt < CW'(MAX_SYMBOLS)) begin
                            n_sym_bits[r_sym_cnt[IW-1:0]] = (r_elapsed > r_short_max);
                            n_sym_cnt = r_sym_cnt + CW'(1);
                        end else begin
                            n_sym_ovf = 1'b1;
                        end
                    end
                    n_last_level = r_high_level;
                end else begin
                    n_last_level = r_low_level;
                end
                n_last_valid = 1'b1;
                n_elapsed    = 16'd0;
                n_armed      = 1'b1;
            end
        end else begin
            n_elapsed = w_elapsed_inc;
            if (r_armed && w_elapsed_inc >= r_long_max) begin
                n_fire     = 1'b1;
                n_armed    = 1'b0;
                n_sym_bits = '0;
                n_sym_cnt  = '0;
                n_sym_ovf  = 1'b0;
                if (r_last_valid && r_last_level == r_high_level) begin
                    n_out_word.char_code = w_code;
                    n_out_word.status    = (w_code != 7'h00) ? STATUS_DECODED
                                                             : STATUS_NOT_FOUND;
                end else begin
                    n_out_word.char_code = 7'h00;
                    n_out_word.status    = STATUS_ABORTED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_level  <= LOW_LEVEL_RESET;
            r_high_level <= HIGH_LEVEL_RESET;
            r_short_max  <= SHORT_MAX_RESET;
            r_long_max   <= LONG_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_index'(i_cfg_index))
                REG_LOW_LEVEL:  r_low_level  <= i_cfg_data;
                REG_HIGH_LEVEL: r_high_level <= i_cfg_data;
                REG_SHORT_MAX:  r_short_max  <= i_cfg_data;
                REG_LONG_MAX:   r_long_max   <= i_cfg_data;
                default:        r_low_level  <= r_low_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= '0;
            r_last_valid <= 1'b0;
            r_elapsed    <= '0;
            r_armed      <= 1'b0;
            r_sym_bits   <= '0;
            r_sym_cnt    <= '0;
            r_sym_ovf    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_last_level <= n_last_level;
                r_last_valid <= n_last_valid;
                r_elapsed    <= n_elapsed;
                r_armed      <= n_armed;
                r_sym_bits   <= n_sym_bits;
                r_sym_cnt    <= n_sym_cnt;
                r_sym_ovf    <= n_sym_ovf;
            end
            if (w_accept && n_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
